FILE: src/slcf_pkg.sv
// Shared constants and types for the serial line command filter.
`timescale 1ns / 1ps

package slcf_pkg;

  // Ring of received bytes; holds RING_DEPTH-1 bytes
  localparam int unsigned RING_DEPTH = 32;
  localparam int unsigned IDX_W      = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  // Character codes
  localparam logic [7:0] CHAR_CR        = 8'd13;
  localparam logic [7:0] CHAR_LF        = 8'd10;
  localparam logic [7:0] CMD_CHAR_RESET = 8'd94;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_COMMAND_CHAR = 1'b0,
    REG_LINK_ENABLE  = 1'b1
  } reg_idx_e;

  // Input word kinds
  typedef enum logic {
    MODE_RX   = 1'b0,
    MODE_READ = 1'b1
  } mode_e;

  // One result word
  typedef struct packed {
    logic       forward_valid;
    logic [7:0] forward_byte;
    logic       line_end;
    logic       command_end;
    logic       byte_dropped;
    logic       read_valid;
    logic [7:0] read_byte;
  } res_t;

endpackage

FILE: src/serial_line_command_filter_core.sv
// Top level of the serial line command filter: line and command tracking, byte ring.
`timescale 1ns / 1ps

// Serial line command filter.
// Input channel (in_valid_i / in_stall_o) carries one word per handshake: either
// a received byte (mode_i = 0, rx_byte_i) or a read request (mode_i = 1).
// Output channel (out_valid_o / out_stall_i) returns exactly one result word per
// input word: forwarding to the partner port, line end, command end, drop flag
// and, for a read request, the oldest byte popped from the 32-entry ring.
// Configuration (cfg_we_i, cfg_index_i, cfg_data_i): index 0 is the command
// character, index 1 the link enable; write only while the block is idle.
// The result of an accepted word is registered in the output or skid register.
// Throughput: one word per cycle while in_stall_o is low; the state update for a
// word is a single compare/increment pass, and the ring is pre-read ahead so its
// registered read port never delays a result.
// Stall: the result sits in the output register; a skid register takes one
// more word, after which in_stall_o rises until the receiver drains it.
// Reset: pointers, line and command state clear, the command character goes
// to '^' and the link is disabled. The ring contents need no clearing, as only
// written entries are ever popped.
module serial_line_command_filter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] rx_byte_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       forward_valid_o,
  output logic [7:0] forward_byte_o,
  output logic       line_end_o,
  output logic       command_end_o,
  output logic       byte_dropped_o,
  output logic       read_valid_o,
  output logic [7:0] read_byte_o
);

  localparam int unsigned IW = slcf_pkg::IDX_W;

  logic [7:0]    cmd_char_q;
  logic          link_en_q;
  logic [IW-1:0] widx_q, widx_d;
  logic [IW-1:0] ridx_q, ridx_d;
  logic          last_enter_q, last_enter_d;
  logic          in_cmd_q, in_cmd_d;

  logic [7:0]    ring_q [slcf_pkg::RING_DEPTH];
  logic [7:0]    mem_rd_q;
  logic          byp_q;
  logic [7:0]    byp_data_q;
  logic [7:0]    head_byte;

  logic          accept, taken;
  logic          store;
  logic [IW-1:0] widx_nx, ridx_nx;
  logic          empty, full, is_eol;
  slcf_pkg::res_t res;

  slcf_pkg::res_t out_q, skid_q;
  logic           out_valid_q, skid_valid_q;

  // Handshakes
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign taken      = out_valid_q && !out_stall_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_char_q <= slcf_pkg::CMD_CHAR_RESET;
      link_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (slcf_pkg::reg_idx_e'(cfg_index_i))
        slcf_pkg::REG_COMMAND_CHAR: cmd_char_q <= cfg_data_i;
        slcf_pkg::REG_LINK_ENABLE:  link_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Ring pointer arithmetic
  assign widx_nx = (widx_q == slcf_pkg::LAST_IDX) ? '0 : widx_q + 1'b1;
  assign ridx_nx = (ridx_q == slcf_pkg::LAST_IDX) ? '0 : ridx_q + 1'b1;
  assign empty   = (ridx_q == widx_q);
  assign full    = (widx_nx == ridx_q);
  assign is_eol  = (rx_byte_i == slcf_pkg::CHAR_CR) || (rx_byte_i == slcf_pkg::CHAR_LF);

  // Oldest stored byte, pre-read last cycle
  assign head_byte = byp_q ? byp_data_q : mem_rd_q;

  // Single pass over one word: result and next state
  always_comb begin
    res          = '0;
    widx_d       = widx_q;
    ridx_d       = ridx_q;
    last_enter_d = last_enter_q;
    in_cmd_d     = in_cmd_q;
    store        = 1'b0;
    if (accept) begin
      if (slcf_pkg::mode_e'(mode_i) == slcf_pkg::MODE_READ) begin
        if (!empty) begin
          res.read_valid = 1'b1;
          res.read_byte  = head_byte;
          ridx_d         = ridx_nx;
        end
      end else begin
        if (is_eol) begin
          res.line_end    = !last_enter_q;
          res.command_end = !last_enter_q && in_cmd_q;
          last_enter_d    = 1'b1;
        end else begin
          last_enter_d = 1'b0;
          if (last_enter_q) begin
            in_cmd_d = 1'b0;
          end
          if (full) begin
            res.byte_dropped = 1'b1;
          end else begin
            store  = 1'b1;
            widx_d = widx_nx;
          end
          if (rx_byte_i == cmd_char_q) begin
            in_cmd_d = 1'b1;
          end
        end
        if (!in_cmd_d && link_en_q) begin
          res.forward_valid = 1'b1;
          res.forward_byte  = rx_byte_i;
        end
      end
    end
  end

  // Pointers and line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q       <= '0;
      ridx_q       <= '0;
      last_enter_q <= 1'b0;
      in_cmd_q     <= 1'b0;
    end else begin
      widx_q       <= widx_d;
      ridx_q       <= ridx_d;
      last_enter_q <= last_enter_d;
      in_cmd_q     <= in_cmd_d;
    end
  end

  // Ring memory: one write port, one registered read at the next head
  always_ff @(posedge clk_i) begin
    if (store) begin
      ring_q[widx_q] <= rx_byte_i;
    end
    mem_rd_q <= ring_q[ridx_d];
  end

  // Write-to-head bypass for the pre-read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= store && (widx_q == ridx_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      byp_data_q <= rx_byte_i;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (taken) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || taken) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (taken) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (taken) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || taken) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  // Output ports
  assign out_valid_o     = out_valid_q;
  assign forward_valid_o = out_q.forward_valid;
  assign forward_byte_o  = out_q.forward_byte;
  assign line_end_o      = out_q.line_end;
  assign command_end_o   = out_q.command_end;
  assign byte_dropped_o  = out_q.byte_dropped;
  assign read_valid_o    = out_q.read_valid;
  assign read_byte_o     = out_q.read_byte;

endmodule
